// ===== hw/rtl/kor_pkg.sv =====
// Shared types, constants and nibble coding functions for the k-mer encoder.
`default_nettype none
package kor_pkg;

  localparam int MAX_K  = 16;
  localparam int NIB_W  = 4;
  localparam int CODE_W = MAX_K * NIB_W;
  localparam int K_W    = $clog2(MAX_K + 1);
  localparam int CHAR_W = 8;
  localparam int IDX_W  = $clog2(MAX_K);
  localparam int CFG_W  = K_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE = 1'd1;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [NIB_W-1:0] NIB_A = 4'b1000;
  localparam logic [NIB_W-1:0] NIB_C = 4'b0100;
  localparam logic [NIB_W-1:0] NIB_T = 4'b0010;
  localparam logic [NIB_W-1:0] NIB_G = 4'b0001;

  localparam logic [NIB_W-1:0] THERMO_A = 4'b1111;
  localparam logic [NIB_W-1:0] THERMO_C = 4'b1110;
  localparam logic [NIB_W-1:0] THERMO_T = 4'b1100;
  localparam logic [NIB_W-1:0] THERMO_G = 4'b1000;

  typedef struct packed {
    logic [CHAR_W-1:0] base_char;
    logic              seq_start;
  } char_t;

  typedef struct packed {
    logic [CODE_W-1:0] kmer_code;
    logic              is_reverse;
    logic              last_of_run;
  } kmer_t;

  function automatic logic [NIB_W-1:0] onehot_of(input logic [CHAR_W-1:0] ch);
    logic [NIB_W-1:0] n;
    case (ch)
      CHAR_A:  n = NIB_A;
      CHAR_C:  n = NIB_C;
      CHAR_T:  n = NIB_T;
      CHAR_G:  n = NIB_G;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [NIB_W-1:0] comp_nib(input logic [NIB_W-1:0] n);
    return {n[1], n[0], n[3], n[2]};
  endfunction

  function automatic logic [NIB_W-1:0] thermo_nib(input logic [NIB_W-1:0] n);
    logic [NIB_W-1:0] t;
    case (n)
      NIB_A:   t = THERMO_A;
      NIB_C:   t = THERMO_C;
      NIB_T:   t = THERMO_T;
      NIB_G:   t = THERMO_G;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kor_cell.sv =====
// One window cell: holds the one-hot nibble of one base and passes it on.
`default_nettype none
module kor_cell
  import kor_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic             clear,
  input  wire logic [NIB_W-1:0] din,
  output logic      [NIB_W-1:0] nib,
  output logic      [NIB_W-1:0] comp
);

  always_ff @(posedge clk) begin
    if (shift) begin
      nib <= clear ? '0 : din;
    end
  end

  assign comp = comp_nib(nib);

endmodule
`default_nettype wire

// ===== hw/rtl/kor_emit.sv =====
// Output stage: holds one forward/reverse pair and presents it as two transfers.
`default_nettype none
module kor_emit
  import kor_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic [CODE_W-1:0] fwd_code,
  input  wire logic [CODE_W-1:0] rev_code,
  output logic                   free,
  output logic                   kmer_valid,
  input  wire logic              kmer_stall,
  output kmer_t                  kmer_data
);

  logic              phase;
  logic [CODE_W-1:0] fwd;
  logic [CODE_W-1:0] rev;

  assign free = !kmer_valid || (phase && !kmer_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (load) begin
      kmer_valid <= 1'b1;
      phase      <= 1'b0;
    end else if (kmer_valid && !kmer_stall) begin
      if (phase) begin
        kmer_valid <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fwd <= fwd_code;
      rev <= rev_code;
    end
  end

  always_comb begin
    kmer_data.kmer_code   = phase ? rev : fwd;
    kmer_data.is_reverse  = phase;
    kmer_data.last_of_run = phase;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kmer_onehot_revcomp_encoder.sv =====
// Top level of the k-mer one-hot encoder with reverse complement output.
// Characters enter one per transfer into a chain of 16 cells, each holding
// the one-hot nibble of one recent base. A character that completes a full
// clean window is flagged in the hit register; its forward and reverse
// k-mers are then loaded into a single output register pair and leave one
// after the other, forward first. While a flagged window waits for that
// register pair to be free, further characters are stalled. The user must
// write registers only while the block is idle; the block itself does not
// enforce it. kmer_len 0 acts as 1 and values above 16 act as 16.
`default_nettype none
module kmer_onehot_revcomp_encoder
  import kor_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 char_valid,
  output logic                      char_stall,
  input  wire char_t                char_data,
  output logic                      kmer_valid,
  input  wire logic                 kmer_stall,
  output kmer_t                     kmer_data
);

  logic [K_W-1:0]    kmer_len;
  logic              encoding_mode;
  logic [K_W-1:0]    k_eff;
  logic [K_W-1:0]    clean_run;
  logic [K_W-1:0]    clean_run_next;
  logic [K_W-1:0]    run_base;
  logic              hit;
  logic              hit_next;
  logic              accept;
  logic              emit_free;
  logic              load;
  logic [NIB_W-1:0]  new_nib;
  logic [NIB_W-1:0]  cell_nib  [MAX_K];
  logic [NIB_W-1:0]  cell_comp [MAX_K];
  logic [CODE_W-1:0] fwd_code;
  logic [CODE_W-1:0] rev_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len      <= K_W'(MAX_K);
      encoding_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KMER_LEN:      kmer_len      <= cfg_data;
        REG_ENCODING_MODE: encoding_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = K_W'(1);
    end else if (kmer_len > K_W'(MAX_K)) begin
      k_eff = K_W'(MAX_K);
    end else begin
      k_eff = kmer_len;
    end
  end

  assign load       = hit && emit_free;
  assign char_stall = hit && !emit_free;
  assign accept     = char_valid && !char_stall;
  assign new_nib    = onehot_of(char_data.base_char);

  always_comb begin
    run_base = char_data.seq_start ? '0 : clean_run;
    if (new_nib == '0) begin
      clean_run_next = '0;
    end else if (run_base < K_W'(MAX_K)) begin
      clean_run_next = run_base + K_W'(1);
    end else begin
      clean_run_next = run_base;
    end
    hit_next = (new_nib != '0) && (clean_run_next >= k_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clean_run <= '0;
      hit       <= 1'b0;
    end else begin
      if (accept) begin
        clean_run <= clean_run_next;
        hit       <= hit_next;
      end else if (load) begin
        hit <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    if (i == 0) begin : g_head
      kor_cell u_cell (
        .clk   (clk),
        .shift (accept),
        .clear (1'b0),
        .din   (new_nib),
        .nib   (cell_nib[i]),
        .comp  (cell_comp[i])
      );
    end else begin : g_body
      kor_cell u_cell (
        .clk   (clk),
        .shift (accept),
        .clear (char_data.seq_start),
        .din   (cell_nib[i-1]),
        .nib   (cell_nib[i]),
        .comp  (cell_comp[i])
      );
    end
  end

  always_comb begin
    logic [K_W-1:0]   age;
    logic [NIB_W-1:0] f;
    logic [NIB_W-1:0] r;
    fwd_code = '0;
    rev_code = '0;
    for (int q = 0; q < MAX_K; q++) begin
      age = k_eff - K_W'(1) - K_W'(q);
      f   = cell_nib[q];
      r   = cell_comp[age[IDX_W-1:0]];
      if (encoding_mode) begin
        f = thermo_nib(f);
        r = thermo_nib(r);
      end
      if (K_W'(q) < k_eff) begin
        fwd_code[q*NIB_W +: NIB_W] = f;
        rev_code[q*NIB_W +: NIB_W] = r;
      end
    end
  end

  kor_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .fwd_code   (fwd_code),
    .rev_code   (rev_code),
    .free       (emit_free),
    .kmer_valid (kmer_valid),
    .kmer_stall (kmer_stall),
    .kmer_data  (kmer_data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/kor_checker.sv =====
// Port-level checks for the k-mer encoder, bound to the top level.
`default_nettype none
module kor_checker
  import kor_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  kmer_valid,
  input wire logic  kmer_stall,
  input wire kmer_t kmer_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    kmer_valid && kmer_stall |=> kmer_valid && $stable(kmer_data))
    else $error("stalled k-mer changed");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    kmer_valid && !kmer_stall && !kmer_data.is_reverse |=>
      kmer_valid && kmer_data.is_reverse)
    else $error("forward transfer not followed by reverse");

  a_last: assert property (@(posedge clk) disable iff (rst)
    kmer_valid |-> kmer_data.is_reverse == kmer_data.last_of_run)
    else $error("last_of_run differs from is_reverse");

  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    kmer_valid |-> kmer_data.kmer_code != '0)
    else $error("empty k-mer code");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !kmer_valid)
    else $error("output valid right after reset");

endmodule

bind kmer_onehot_revcomp_encoder kor_checker u_kor_checker (
  .clk        (clk),
  .rst        (rst),
  .kmer_valid (kmer_valid),
  .kmer_stall (kmer_stall),
  .kmer_data  (kmer_data)
);
`default_nettype wire
